### rtl/sakc_pkg.sv
// Package for the sorted array key counter.
// Holds field widths, the item mode codes, the controller state type and the
// command and status structs shared by the controller and the datapath.
package sakc_pkg;

  localparam int MODE_W  = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LB_RD,
    ST_LB_CMP,
    ST_HIT_CMP,
    ST_UB_RD,
    ST_UB_CMP,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;    // write the input value at the end of the table
    logic clear;     // empty the table
    logic start;     // latch the key, open the window, zero the result
    logic rd_mid;    // read the entry at the window midpoint
    logic rd_low;    // read the entry at the lower bound and latch it
    logic step;      // narrow the window from the read entry
    logic strict;    // step compares with "greater than key"
    logic restart;   // reopen the window for the second search
    logic res_diff;  // result is the distance between the two bounds
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_zero;
    logic search_done;
    logic key_hit;
  } status_t;

endpackage

### rtl/sakc_in_if.sv
// Input channel of the sorted array key counter: valid, ready and one word.
// Depends on sakc_pkg for the field widths.
interface sakc_in_if;
  logic                                valid;
  logic                                ready;
  logic [sakc_pkg::MODE_W-1:0]         mode;
  logic signed [sakc_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

### rtl/sakc_out_if.sv
// Output channel of the sorted array key counter: valid, ready and one word.
// Depends on sakc_pkg for the field width.
interface sakc_out_if;
  logic                         valid;
  logic                         ready;
  logic [sakc_pkg::COUNT_W-1:0] match_count;

  modport source (output valid, output match_count, input ready);
  modport sink   (input valid, input match_count, output ready);
endinterface

### rtl/sakc_ctrl.sv
// Controller of the sorted array key counter: sequences appends, clears and
// the two binary searches of a query. Depends on sakc_pkg.
module sakc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [sakc_pkg::MODE_W-1:0] in_mode_i,
  output logic                        in_ready_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  input  sakc_pkg::status_t           status_i,
  output sakc_pkg::cmd_t              cmd_o
);
  import sakc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  mode_e  mode;

  assign mode      = mode_e'(in_mode_i);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (mode == MODE_QUERY)) begin
          state_d = status_i.fill_zero ? ST_EMIT : ST_LB_RD;
        end
      end
      ST_LB_RD:   state_d = status_i.search_done ? ST_HIT_CMP : ST_LB_CMP;
      ST_LB_CMP:  state_d = ST_LB_RD;
      ST_HIT_CMP: state_d = status_i.key_hit ? ST_UB_RD : ST_EMIT;
      ST_UB_RD:   state_d = status_i.search_done ? ST_EMIT : ST_UB_CMP;
      ST_UB_CMP:  state_d = ST_UB_RD;
      ST_EMIT: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (mode)
            MODE_APPEND: cmd_o.append = 1'b1;
            MODE_QUERY:  cmd_o.start  = 1'b1;
            MODE_CLEAR:  cmd_o.clear  = 1'b1;
            default:     cmd_o        = '0;
          endcase
        end
      end
      ST_LB_RD: begin
        if (status_i.search_done) begin
          cmd_o.rd_low = 1'b1;
        end else begin
          cmd_o.rd_mid = 1'b1;
        end
      end
      ST_LB_CMP: cmd_o.step = 1'b1;
      ST_HIT_CMP: begin
        if (status_i.key_hit) begin
          cmd_o.restart = 1'b1;
        end
      end
      ST_UB_RD: begin
        if (status_i.search_done) begin
          cmd_o.res_diff = 1'b1;
        end else begin
          cmd_o.rd_mid = 1'b1;
        end
      end
      ST_UB_CMP: begin
        cmd_o.step   = 1'b1;
        cmd_o.strict = 1'b1;
      end
      ST_EMIT: cmd_o.out_load = slot_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/sakc_dp.sv
// Datapath of the sorted array key counter: element memory, fill count,
// search window, bound registers and the output register. Depends on sakc_pkg.
module sakc_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [sakc_pkg::VALUE_W-1:0] in_value_i,
  input  sakc_pkg::cmd_t                      cmd_i,
  output sakc_pkg::status_t                   status_o,
  output logic [sakc_pkg::COUNT_W-1:0]        out_count_o
);
  import sakc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];

  logic [CW-1:0]             fill_q, fill_d;
  logic [CW-1:0]             lo_q, lo_d;
  logic [CW-1:0]             hi_q, hi_d;
  logic [CW-1:0]             first_q;
  logic signed [VALUE_W-1:0] key_q;
  logic signed [VALUE_W-1:0] rdata_q;
  logic [COUNT_W-1:0]        res_q;
  logic [COUNT_W-1:0]        out_q;

  logic [CW-1:0] mid;
  logic [AW-1:0] rd_addr;
  logic          full;
  logic          go_right;

  assign mid      = lo_q + ((hi_q - lo_q) >> 1);
  assign rd_addr  = cmd_i.rd_low ? lo_q[AW-1:0] : mid[AW-1:0];
  assign full     = (fill_q == CW'(TABLE_DEPTH));
  assign go_right = cmd_i.strict ? (rdata_q <= key_q) : (rdata_q < key_q);

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.clear) begin
      fill_d = '0;
    end else if (cmd_i.append && !full) begin
      fill_d = fill_q + CW'(1);
    end
  end

  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.start || cmd_i.restart) begin
      lo_d = '0;
      hi_d = fill_q;
    end else if (cmd_i.step) begin
      if (go_right) begin
        lo_d = mid + CW'(1);
      end else begin
        hi_d = mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (cmd_i.start) begin
      key_q <= in_value_i;
      res_q <= '0;
    end
    if (cmd_i.rd_low) begin
      first_q <= lo_q;
    end
    if (cmd_i.res_diff) begin
      res_q <= (lo_q > first_q) ? COUNT_W'(lo_q - first_q) : '0;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  // Element memory: one write port for appends, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && !full) begin
      mem[fill_q[AW-1:0]] <= in_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_mid || cmd_i.rd_low) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign status_o.fill_zero   = (fill_q == '0);
  assign status_o.search_done = (lo_q >= hi_q);
  assign status_o.key_hit     = (first_q < fill_q) && (rdata_q == key_q);
  assign out_count_o          = out_q;

endmodule

### rtl/sorted_array_key_count.sv
// Top level of the sorted array key counter.
// Instantiates sakc_ctrl and sakc_dp; uses sakc_pkg, sakc_in_if and sakc_out_if.
//
//   Channel  Dir  Word fields                  Words that produce output
//   in_i     in   mode[1:0], value[31:0] sgn   query only (one result)
//   out_o    out  match_count[10:0]            -
//
// An append, a clear or an unused mode is taken in the idle state, which the
// controller does not leave. A query holds the input off while it walks the
// lower bound search, the hit compare, the upper bound search and the emit
// state; each search takes at most ceil(log2(fill+1)) probes, and the count
// turns valid in the same cycle as the input reopens. A key that misses
// skips the second search. Each probe is a read state for the registered
// memory read port and a compare state that narrows the window.
// A query on an empty table goes straight to the emit state.
// Reset clears the fill count and the controller; the memory is not cleared.
// A finished count waits in the output register while new words are taken;
// the next query stalls at its end until that register is free.
module sorted_array_key_count #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sakc_in_if.sink    in_i,
  sakc_out_if.source out_o
);
  import sakc_pkg::*;

  // Control and status between the sequencer and the datapath.
  cmd_t    cmd;
  status_t status;

  // The sequencer walks both searches: a read state issues the probe at the
  // window midpoint and the compare state that follows narrows the window.
  sakc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the table, the lower and upper bound window, the
  // latched lower bound and the count that goes out on the output channel.
  sakc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (in_i.value),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_count_o (out_o.match_count)
  );

endmodule

### rtl/sakc_checker.sv
// Port-level checks for the sorted array key counter and the bind that
// attaches them to the top level. Depends on sakc_pkg.
module sakc_checker #(
  parameter int TABLE_DEPTH = 1024
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [sakc_pkg::MODE_W-1:0]  in_mode_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [sakc_pkg::COUNT_W-1:0] out_count_i
);
  import sakc_pkg::*;

  // A held result keeps its word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_count_i))
    else $error("output word changed while stalled");

  // A query occupies the block for at least the cycle after it is taken.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == MODE_QUERY) |=> !in_ready_i)
    else $error("input taken while a query is in progress");

  // An append leaves the block idle and ready for another word.
  a_append_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == MODE_APPEND) |=> in_ready_i)
    else $error("append did not return to idle");

  // A new result only appears at the end of a query.
  a_result_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a query in progress");

  // A count never exceeds the table size; checked for depths up to 2047.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (TABLE_DEPTH > 2047) || (32'(out_count_i) <= 32'(TABLE_DEPTH)))
    else $error("count exceeds table depth");

endmodule

bind sorted_array_key_count sakc_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_sakc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_count_i (out_o.match_count)
);
